@@ sv/merge_sort_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// merge sort engine assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_UNIT_DEFINES_SVH
`define MERGE_SORT_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define MSE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("merge sort engine: same-cycle check failed");

// next-cycle implication
`define MSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("merge sort engine: next-cycle check failed");

`endif

@@ sv/mse_pkg.sv @@
// ----------------------------------------------------------------------------
// merge sort engine package
// shared types and constants for the sorting cell chain
// ----------------------------------------------------------------------------
package mse_pkg;

   localparam int unsigned DATA_W = 32;

   typedef logic [DATA_W-1:0] data_type;

   // broadcast control for every cell in the chain
   typedef struct packed {
      logic     ins;    // insert the broadcast value
      logic     shl;    // shift contents one cell toward the output
      data_type value;  // value being inserted
   } cell_ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

@@ sv/merge_sort_engine_unit.sv @@
// loading: a set of values loads at one request per cycle; the smallest value is
// offered in the cycle after the closing request, then one result per cycle while
// rsp_tready is high; the drain phase holds off requests
// the chain of SLOTS compare cells does one insert or one shift a cycle
// reset: synchronous active high, empties the chain, count and overflow flag
// ----------------------------------------------------------------------------
// merge sort engine unit
// insertion into a row of sorting cells, then shift-out in ascending order
// ----------------------------------------------------------------------------
`include "merge_sort_engine_unit_defines.svh"

module merge_sort_engine_unit #(
   parameter int unsigned SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,   // last_res
   output logic        rsp_tuser    // [0] overflow
);

   localparam int unsigned CNT_W = $clog2(SLOTS + 1);

   mse_pkg::state_type     state_ff;
   mse_pkg::state_type     state_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   drop_ff;
   logic                   drop_in;
   mse_pkg::cell_ctrl_type ctrl;

   logic                   req_acc;
   logic                   rsp_acc;
   logic                   full;

   logic                   take_w  [0:SLOTS];
   logic                   valid_w [0:SLOTS];
   mse_pkg::data_type      value_w [0:SLOTS];

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign full    = (count_ff == CNT_W'(SLOTS));

   assign ctrl.ins   = req_acc && !full;
   assign ctrl.shl   = rsp_acc;
   assign ctrl.value = req_tdata;

   // chain boundaries: nothing passes in from the head, empties from the tail
   assign take_w[0]      = 1'b0;
   assign valid_w[SLOTS] = 1'b0;
   assign value_w[SLOTS] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      mse_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_take   (take_w[i]),
         .left_valid  ((i == 0) ? 1'b0 : valid_w[(i == 0) ? 0 : i - 1]),
         .left_value  (value_w[(i == 0) ? 0 : i - 1]),
         .right_valid (valid_w[i + 1]),
         .right_value (value_w[i + 1]),
         .take        (take_w[i + 1]),
         .valid       (valid_w[i]),
         .value       (value_w[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mse_pkg::ST_LOAD: begin
            if (req_acc && req_tlast) begin
               state_in = mse_pkg::ST_DRAIN;
            end
         end
         mse_pkg::ST_DRAIN: begin
            if (rsp_acc && (count_ff == CNT_W'(1))) begin
               state_in = mse_pkg::ST_LOAD;
            end
         end
         default: state_in = mse_pkg::ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         mse_pkg::ST_LOAD:  req_tready = 1'b1;
         mse_pkg::ST_DRAIN: rsp_tvalid = 1'b1;
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      priority if (rsp_acc) begin
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            drop_in = 1'b0;
         end
      end else if (req_acc) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mse_pkg::ST_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   assign rsp_tdata = value_w[0];
   assign rsp_tlast = (count_ff == CNT_W'(1));
   assign rsp_tuser = drop_ff;

   `MSE_ASSERT_SAME(a_rsp_has_data, rsp_tvalid, (count_ff != '0) && valid_w[0])
   `MSE_ASSERT_SAME(a_head_matches_count, count_ff != '0, valid_w[0])
   `MSE_ASSERT_SAME(a_head_sorted, valid_w[1], $signed(value_w[0]) <= $signed(value_w[1]))
   `MSE_ASSERT_NEXT(a_close_drains, req_acc && req_tlast, rsp_tvalid)
   `MSE_ASSERT_NEXT(a_full_drops, req_acc && full, drop_ff)

endmodule

@@ sv/mse_cell.sv @@
// ----------------------------------------------------------------------------
// merge sort engine cell
// one slot of the sorted chain: compares the broadcast value with its own,
// takes it, passes its own to the right, or shifts toward the output
// ----------------------------------------------------------------------------
module mse_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mse_pkg::cell_ctrl_type ctrl,
   input  logic                  left_take,
   input  logic                  left_valid,
   input  mse_pkg::data_type     left_value,
   input  logic                  right_valid,
   input  mse_pkg::data_type     right_value,
   output logic                  take,
   output logic                  valid,
   output mse_pkg::data_type     value
);

   logic              valid_ff;
   logic              valid_in;
   mse_pkg::data_type value_ff;
   mse_pkg::data_type value_in;

   // empty slots sit at the tail, so take is monotone along the chain
   assign take = !valid_ff || ($signed(ctrl.value) < $signed(value_ff));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      priority if (ctrl.shl) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctrl.ins) begin
         if (left_take) begin
            valid_in = left_valid;
            value_in = left_value;
         end else if (take) begin
            valid_in = 1'b1;
            value_in = ctrl.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// merge sort engine unit testbench
// sends sets of signed values and checks that each set comes back in
// ascending order, with last on the final value and the overflow flag on
// sets that lost values to a full store
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned SLOTS = 64;
   localparam int unsigned RANDOM_ITEMS = 200;

   typedef logic signed [mse_pkg::DATA_W-1:0] elem_type;

   localparam elem_type VAL_MIN = 32'sh8000_0000;
   localparam elem_type VAL_MAX = 32'sh7fff_ffff;

   typedef struct {
      elem_type value;
      logic     last_flag;
      logic     overflow;
   } sort_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic        req_tlast = 1'b0; // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] sorted_value
   logic        rsp_tlast;        // last_res
   logic        rsp_tuser;        // [0] overflow

   // model of the block: values held so far in ascending order
   elem_type        sorted_set[$];
   logic            dropped;
   sort_result_type pending_results[$];

   int unsigned  error_count = 0;
   int unsigned  sent_count = 0;
   int unsigned  hold_cycles = 0;
   bit           calm = 0;

   merge_sort_engine_unit #(
      .SLOTS(SLOTS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned draw_wait();
      if (calm) return 0;
      return $urandom_range(0, 19);
   endfunction

   function automatic elem_type draw_value();
      case ($urandom_range(0, 5))
         0, 1, 5: return $urandom;
         2:       return elem_type'($urandom_range(0, 8)) - 4;
         3: begin
            case ($urandom_range(0, 5))
               0: return VAL_MIN;
               1: return VAL_MAX;
               2: return 0;
               3: return -1;
               4: return VAL_MIN + 1;
               default: return VAL_MAX - 1;
            endcase
         end
         default: return VAL_MIN | elem_type'($urandom_range(0, 15));
      endcase
   endfunction

   // insert into the sorted set, or mark the set as overflowed when full;
   // the closing request releases the whole set
   task automatic sort_absorb(input elem_type value, input logic last);
      int pos;
      sort_result_type res;
      if (sorted_set.size() < SLOTS) begin
         pos = sorted_set.size();
         while (pos > 0 && value < sorted_set[pos-1]) pos--;
         sorted_set.insert(pos, value);
      end else begin
         dropped = 1'b1;
      end
      if (last) begin
         foreach (sorted_set[k]) begin
            res.value     = sorted_set[k];
            res.last_flag = (k == sorted_set.size() - 1);
            res.overflow  = dropped;
            pending_results.push_back(res);
         end
         sorted_set.delete();
         dropped = 1'b0;
      end
   endtask

   task automatic push_request(input elem_type value, input logic last);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      sort_absorb(value, last);
   endtask

   task automatic send_set(input int unsigned count);
      for (int unsigned i = 1; i <= count; i++) push_request(draw_value(), i == count);
   endtask

   // result side: check each accepted result, then stall for a random while
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: sorted_value %0d", $signed(rsp_tdata));
               error_count++;
            end else begin
               sort_result_type want;
               want = pending_results.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("sorted_value: expected %0d, got %0d", want.value, $signed(rsp_tdata));
                  error_count++;
               end
               if (rsp_tlast !== want.last_flag) begin
                  $error("last_res: expected %0d, got %0d", want.last_flag, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser !== want.overflow) begin
                  $error("overflow: expected %0d, got %0d", want.overflow, rsp_tuser);
                  error_count++;
               end
            end
            hold_cycles = draw_wait();
            if (hold_cycles != 0) rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (hold_cycles <= 1) rsp_tready <= 1'b1;
            if (hold_cycles != 0) hold_cycles--;
         end
      end
   end

   task automatic test_single_item();
      push_request(-5, 1'b1);
      push_request(0, 1'b1);
   endtask

   task automatic test_extremes();
      push_request(VAL_MAX, 1'b0);
      push_request(VAL_MIN, 1'b0);
      push_request(-1, 1'b0);
      push_request(0, 1'b0);
      push_request(1, 1'b0);
      push_request(VAL_MIN + 1, 1'b0);
      push_request(VAL_MAX - 1, 1'b1);
   endtask

   task automatic test_duplicates();
      push_request(5, 1'b0);
      push_request(5, 1'b0);
      push_request(-5, 1'b0);
      push_request(5, 1'b0);
      push_request(-5, 1'b1);
   endtask

   task automatic test_descending();
      for (int i = 3; i >= -2; i--) push_request(i, i == -2);
   endtask

   task automatic test_full_store();
      calm = 1;
      send_set(SLOTS);        // exactly full, nothing dropped
      calm = 0;
      send_set(SLOTS + 1);    // closing request itself is dropped
      send_set(SLOTS + 6);
   endtask

   task automatic test_random_sets();
      int unsigned n;
      int unsigned start;
      start = sent_count;
      while (sent_count - start < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 19))
            0:       n = $urandom_range(SLOTS, SLOTS + 8);
            1, 2:    n = $urandom_range(13, SLOTS - 1);
            default: n = $urandom_range(1, 12);
         endcase
         send_set(n);
      end
      calm = 0;
   endtask

   initial begin
      dropped = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_item();
      test_extremes();
      test_duplicates();
      test_descending();
      test_full_store();
      test_random_sets();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
